[src/pretrigger_clip_capture_defines.svh]
// Assertion macros shared by the capture block's RTL files.
// Included by bare file name; no other dependencies.
`ifndef PRETRIGGER_CLIP_CAPTURE_DEFINES_SVH
`define PRETRIGGER_CLIP_CAPTURE_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked check that is switched off while reset is asserted.
`define PCC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define PCC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PCC_ASSERT(label, clk, rst_n, prop, msg)
`define PCC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[src/pcc_pkg.sv]
// Shared types, codes and the PCM conversion function for the capture block.
// No dependencies; every module of the block imports this package.
`default_nettype none

package pcc_pkg;

    // Default ring size: 2**RING_AW_DEF frames.
    localparam int RING_AW_DEF = 16;

    localparam int FRAME_W  = 48;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int LEN_W    = 17;
    localparam int CLIPNO_W = 32;
    localparam int PCM_W    = 16;

    // Operation codes of an input beat.
    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_EVENT = 3'd1;
    localparam logic [2:0] OP_TICK  = 3'd2;
    localparam logic [2:0] OP_FLUSH = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Result kinds.
    localparam logic KIND_CLIP = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PRE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 2'd2;

    localparam logic [CFG_W-1:0] MAX_FRAMES_RST = 24'hFF_FFFF;

    typedef struct packed {
        logic [2:0]          op;
        logic signed [23:0]  left_sample;
        logic signed [23:0]  right_sample;
        logic [FRAME_W-1:0]  frame_index;
    } item_t;

    typedef struct packed {
        logic                     kind;
        logic [FRAME_W-1:0]       clip_start;
        logic [LEN_W-1:0]         clip_frames;
        logic [CLIPNO_W-1:0]      clip_number;
        logic signed [PCM_W-1:0]  left_pcm;
        logic signed [PCM_W-1:0]  right_pcm;
    } result_t;

    // Command from the top level to the clip tracker.
    typedef struct packed {
        logic       valid;
        logic [2:0] op;
    } clip_cmd_t;

    // Closed clip descriptor offered by the clip tracker.
    typedef struct packed {
        logic                 valid;
        logic [FRAME_W-1:0]   start;
        logic [LEN_W-1:0]     frames;
        logic [CLIPNO_W-1:0]  number;
    } clip_desc_t;

    // Q2.22 sample to 16-bit PCM: clamp to +/-1.0, scale by 32767 and
    // truncate toward zero. Works on the magnitude so truncation is exact.
    function automatic logic [PCM_W-1:0] to_pcm(input logic signed [23:0] v);
        logic [22:0]      mag;
        logic [37:0]      prod;
        logic [PCM_W-1:0] q;
        if (v > 24'sd4194304)
            mag = 23'd4194304;
        else if (v < -24'sd4194304)
            mag = 23'd4194304;
        else if (v[23])
            mag = 23'(-v);
        else
            mag = v[22:0];
        prod = 38'(mag) * 38'(15'd32767);
        q = {1'b0, prod[36:22]};
        return v[23] ? (~q + 16'd1) : q;
    endfunction

endpackage

`default_nettype wire

[src/pcc_ring.sv]
// Ring frame memory with one write port and one registered read port.
// Depends on pcc_pkg; slots not yet written since reset read as zero.
`default_nettype none

module pcc_ring #(
    parameter int RING_AW = pcc_pkg::RING_AW_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic [RING_AW-1:0] head,
    input  wire logic [31:0]        wr_data,
    input  wire logic               rd_en,
    input  wire logic [RING_AW-1:0] rd_slot,
    output logic [31:0]             rd_data
);
    import pcc_pkg::*;

    localparam int DEPTH = 1 << RING_AW;

    logic [31:0] mem [DEPTH];
    logic [31:0] mem_q_reg;
    logic        blank_reg;
    logic        wrapped_reg;
    logic        wrapped_next;

    // Once the head has passed the last slot every slot holds pushed data.
    always_comb
    begin
        wrapped_next = wrapped_reg;
        if (wr_en && (head == {RING_AW{1'b1}}))
            wrapped_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrapped_reg <= 1'b0;
            blank_reg   <= 1'b0;
        end
        else
        begin
            wrapped_reg <= wrapped_next;
            if (rd_en)
                blank_reg <= !wrapped_reg && (rd_slot >= head);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[head] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            mem_q_reg <= mem[rd_slot];
    end

    assign rd_data = blank_reg ? 32'd0 : mem_q_reg;

endmodule

`default_nettype wire

[src/pcc_clip.sv]
// Clip tracker: open, extend and close clips and build the closed-clip window.
// Depends on pcc_pkg and the assertion macros header.
`default_nettype none
`include "pretrigger_clip_capture_defines.svh"

module pcc_clip #(
    parameter int RING_AW = pcc_pkg::RING_AW_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [pcc_pkg::CFG_W-1:0]     pre_frames,
    input  wire logic [pcc_pkg::CFG_W-1:0]     post_frames,
    input  wire logic [pcc_pkg::CFG_W-1:0]     max_frames,
    input  wire logic [pcc_pkg::FRAME_W-1:0]   frame_count,
    input  wire pcc_pkg::clip_cmd_t            cmd,
    output logic                               busy,
    output pcc_pkg::clip_desc_t                desc,
    input  wire logic                          desc_take
);
    import pcc_pkg::*;

    localparam logic [FRAME_W:0] RING_SPAN = (FRAME_W + 1)'(1) << RING_AW;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CALC   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_WIN    = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic                clip_open_reg, clip_open_next;
    logic [FRAME_W-1:0]  first_reg, first_next;
    logic [FRAME_W-1:0]  last_reg, last_next;
    logic [CLIPNO_W-1:0] count_reg, count_next;
    logic [FRAME_W-1:0]  ustart_reg, ustart_next;
    logic [FRAME_W:0]    endraw_reg, endraw_next;
    logic [FRAME_W-1:0]  start_reg, start_next;
    logic [FRAME_W-1:0]  end_reg, end_next;

    logic [FRAME_W:0]    fc_ext;
    logic [FRAME_W-1:0]  pre_ext;
    logic [FRAME_W-1:0]  span;
    logic                too_long;
    logic                close_now;
    logic [FRAME_W:0]    len_diff;
    logic                nonempty;

    assign fc_ext   = {1'b0, frame_count};
    assign pre_ext  = {{(FRAME_W - CFG_W){1'b0}}, pre_frames};
    assign span     = frame_count - ustart_reg;
    assign too_long = (frame_count >= ustart_reg)
                      && (span > {{(FRAME_W - CFG_W){1'b0}}, max_frames});
    assign len_diff = {1'b0, end_reg} - {1'b0, start_reg};
    assign nonempty = !len_diff[FRAME_W] && (len_diff != '0);

    always_comb
    begin
        close_now = 1'b0;
        case (op_reg)
            OP_EVENT: close_now = too_long;
            OP_TICK:  close_now = (fc_ext >= endraw_reg);
            OP_FLUSH: close_now = 1'b1;
            default:  close_now = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        clip_open_next = clip_open_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        ustart_next    = ustart_reg;
        endraw_next    = endraw_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.op == OP_EVENT && !clip_open_reg)
                    begin
                        clip_open_next = 1'b1;
                        first_next     = frame_count;
                        last_next      = frame_count;
                    end
                    else if (clip_open_reg)
                    begin
                        if (cmd.op == OP_EVENT)
                            last_next = frame_count;
                        op_next    = cmd.op;
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                ustart_next = (first_reg > pre_ext) ? (first_reg - pre_ext) : '0;
                endraw_next = {1'b0, last_reg}
                              + {{(FRAME_W + 1 - CFG_W){1'b0}}, post_frames};
                state_next  = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (close_now)
                begin
                    clip_open_next = 1'b0;
                    state_next     = ST_WIN;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_WIN:
            begin
                // Clamp the start to what the ring still holds and the end to now.
                if (({1'b0, ustart_reg} + RING_SPAN) < fc_ext)
                    start_next = frame_count - RING_SPAN[FRAME_W-1:0];
                else
                    start_next = ustart_reg;
                if (endraw_reg > fc_ext)
                    end_next = frame_count;
                else
                    end_next = endraw_reg[FRAME_W-1:0];
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!nonempty)
                    state_next = ST_IDLE;
                else if (desc_take)
                begin
                    count_next = count_reg + 32'd1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_PUSH;
            clip_open_reg <= 1'b0;
            first_reg     <= '0;
            last_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            clip_open_reg <= clip_open_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ustart_reg <= ustart_next;
        endraw_reg <= endraw_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign desc.valid  = (state_reg == ST_EMIT) && nonempty;
    assign desc.start  = start_reg;
    assign desc.frames = len_diff[LEN_W-1:0];
    assign desc.number = count_reg + 32'd1;

    `PCC_ASSERT(a_closed_in_window, clk, rst_n, (state_reg == ST_WIN || state_reg == ST_EMIT) |-> !clip_open_reg, "clip still open while its window is built")
    `PCC_ASSERT(a_take_only_offered, clk, rst_n, desc_take |-> desc.valid, "descriptor taken while none offered")
    `PCC_ASSERT(a_take_returns_idle, clk, rst_n, (desc.valid && desc_take) |=> (state_reg == ST_IDLE), "tracker did not return to idle after its descriptor was taken")

endmodule

`default_nettype wire

[src/pretrigger_clip_capture.sv]
// Top level of the pretrigger clip capture block: handshakes, frame counter,
// configuration registers and result register. Depends on pcc_pkg, pcc_ring,
// pcc_clip and the assertion macros header.
//
//  Channel   Signals                          Direction  Beat
//  item      item_valid, item_stall, item     in         one op: push, event, tick, flush, read
//  result    result_valid, result_stall, result  out     clip descriptor or read frame
//  config    cfg_we, cfg_index, cfg_data      in         one register write, no wait
//
// A push converts both samples and writes them to the ring in the cycle the
// beat is accepted. A read passes the registered read port of the ring memory
// and then the result register. An event, tick or flush on an open clip goes
// through the clip tracker's calc and decide states, and also its window and
// emit states when it closes the clip, waiting while the result register stalls.
// Reset needs no clearing pass: the ring tracks how far it has been filled and
// reads untouched slots as zero. Items are accepted while a finished result
// waits, except that a read or a closing clip holds item_stall until its
// result has entered the result register.
`default_nettype none
`include "pretrigger_clip_capture_defines.svh"

module pretrigger_clip_capture #(
    parameter int RING_AW = pcc_pkg::RING_AW_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pcc_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire pcc_pkg::item_t                item,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output pcc_pkg::result_t                   result
);
    import pcc_pkg::*;

    logic [CFG_W-1:0]   pre_reg, post_reg, max_reg;
    logic [FRAME_W-1:0] frame_count_reg, frame_count_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               result_valid_reg, result_valid_next;
    result_t            result_reg, result_next;

    logic               accept;
    logic               push;
    logic               rd_issue;
    logic               out_free;
    logic               load_rd;
    logic               load_desc;
    logic [31:0]        wr_data;
    logic [31:0]        rd_data;
    logic               clip_busy;
    clip_cmd_t          cmd;
    clip_desc_t         desc;

    // One item at a time through the read path or the clip tracker.
    assign item_stall = clip_busy || rd_pend_reg;
    assign accept     = item_valid && !item_stall;
    assign push       = accept && (item.op == OP_PUSH);
    assign rd_issue   = accept && (item.op == OP_READ);

    // Ring words hold left PCM in the low half and right PCM in the high half.
    assign wr_data = {to_pcm(item.right_sample), to_pcm(item.left_sample)};

    assign cmd.valid = accept && (item.op inside {OP_EVENT, OP_TICK, OP_FLUSH});
    assign cmd.op    = item.op;

    assign frame_count_next = push ? (frame_count_reg + 48'd1) : frame_count_reg;

    pcc_ring #(
        .RING_AW (RING_AW)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .head    (frame_count_reg[RING_AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_issue),
        .rd_slot (item.frame_index[RING_AW-1:0]),
        .rd_data (rd_data)
    );

    pcc_clip #(
        .RING_AW (RING_AW)
    ) u_clip (
        .clk         (clk),
        .rst_n       (rst_n),
        .pre_frames  (pre_reg),
        .post_frames (post_reg),
        .max_frames  (max_reg),
        .frame_count (frame_count_reg),
        .cmd         (cmd),
        .busy        (clip_busy),
        .desc        (desc),
        .desc_take   (load_desc)
    );

    // The result register takes a new beat when it is empty or being drained.
    assign out_free  = !result_valid_reg || !result_stall;
    assign load_rd   = rd_pend_reg && out_free;
    assign load_desc = desc.valid && out_free && !rd_pend_reg;

    always_comb
    begin
        rd_pend_next      = rd_pend_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        if (rd_issue)
            rd_pend_next = 1'b1;
        if (load_rd)
        begin
            rd_pend_next            = 1'b0;
            result_valid_next       = 1'b1;
            result_next             = '0;
            result_next.kind        = KIND_READ;
            result_next.left_pcm    = rd_data[15:0];
            result_next.right_pcm   = rd_data[31:16];
        end
        else if (load_desc)
        begin
            result_valid_next       = 1'b1;
            result_next             = '0;
            result_next.kind        = KIND_CLIP;
            result_next.clip_start  = desc.start;
            result_next.clip_frames = desc.frames;
            result_next.clip_number = desc.number;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg          <= '0;
            post_reg         <= '0;
            max_reg          <= MAX_FRAMES_RST;
            frame_count_reg  <= '0;
            rd_pend_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            frame_count_reg  <= frame_count_next;
            rd_pend_reg      <= rd_pend_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PRE:  pre_reg  <= cfg_data;
                    CFG_POST: post_reg <= cfg_data;
                    CFG_MAX:  max_reg  <= cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `PCC_ASSERT(a_one_item_in_flight, clk, rst_n, !(rd_pend_reg && clip_busy), "read pending while the clip tracker is busy")
    `PCC_ASSERT(a_read_goes_pending, clk, rst_n, (item_valid && !item_stall && item.op == OP_READ) |=> rd_pend_reg, "accepted read did not go pending")
    `PCC_ASSERT_ALWAYS(a_reset_no_result, clk, !rst_n |-> !result_valid, "result offered during reset")

endmodule

`default_nettype wire

[bench/clip_capture_checker.sv]
`timescale 1ns / 1ps
// Checker for the pretrigger clip capture block: it watches the config port and
// both channels, predicts each result beat and compares it. Depends on pcc_pkg.
module clip_capture_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          item_valid,
    input  logic                          item_stall,
    input  pcc_pkg::item_t                item,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  pcc_pkg::result_t              result,
    output int                            expected_left,
    output int                            mismatch_count
);
    import pcc_pkg::*;

    localparam longint unsigned RING_SLOTS = 64'd1 << RING_AW_DEF;
    localparam longint FULL_SCALE = 4194304;
    localparam longint PCM_PEAK = 32767;
    localparam int MAX_REPORTS = 10;

    // Shadow copy of the capture state.
    logic [31:0]        ring_copy [0:RING_SLOTS-1];
    logic [FRAME_W-1:0] frames_pushed;
    logic               clip_live;
    logic [FRAME_W-1:0] first_mark;
    logic [FRAME_W-1:0] last_mark;
    logic [31:0]        clips_emitted;
    logic [CFG_W-1:0]   pre_len;
    logic [CFG_W-1:0]   post_len;
    logic [CFG_W-1:0]   max_span;

    result_t expected_beats [$];

    // Clamp to +/-1.0, scale by 32767 and truncate toward zero.
    function automatic logic [PCM_W-1:0] pcm_of(input logic signed [23:0] s);
        longint v;
        longint scaled;
        v = s;
        if (v > FULL_SCALE)
            v = FULL_SCALE;
        else if (v < -FULL_SCALE)
            v = -FULL_SCALE;
        scaled = (v * PCM_PEAK) / FULL_SCALE;
        return scaled[PCM_W-1:0];
    endfunction

    function automatic logic [63:0] raw_start();
        return (64'(first_mark) > 64'(pre_len)) ? 64'(first_mark) - 64'(pre_len) : 64'd0;
    endfunction

    function automatic bit close_clip(output result_t res);
        logic [63:0] lo;
        logic [63:0] hi;
        res = '0;
        if (!clip_live)
            return 1'b0;
        clip_live = 1'b0;
        lo = raw_start();
        // The clip can never reach further back than the ring holds.
        if (lo + RING_SLOTS < 64'(frames_pushed))
            lo = 64'(frames_pushed) - RING_SLOTS;
        hi = 64'(last_mark) + 64'(post_len);
        if (hi > 64'(frames_pushed))
            hi = 64'(frames_pushed);
        if (hi <= lo)
            return 1'b0;
        clips_emitted = clips_emitted + 32'd1;
        res.kind        = KIND_CLIP;
        res.clip_start  = lo[FRAME_W-1:0];
        res.clip_frames = LEN_W'(hi - lo);
        res.clip_number = clips_emitted;
        return 1'b1;
    endfunction

    function automatic bit capture_step(input item_t beat, output result_t res);
        logic [63:0] lo;
        logic [63:0] now;
        res = '0;
        now = 64'(frames_pushed);
        case (beat.op)
            OP_PUSH:
            begin
                ring_copy[frames_pushed[RING_AW_DEF-1:0]] =
                    {pcm_of(beat.right_sample), pcm_of(beat.left_sample)};
                frames_pushed = frames_pushed + 1'b1;
                return 1'b0;
            end
            OP_EVENT:
            begin
                if (!clip_live)
                begin
                    clip_live  = 1'b1;
                    first_mark = frames_pushed;
                    last_mark  = frames_pushed;
                    return 1'b0;
                end
                lo = raw_start();
                last_mark = frames_pushed;
                if (now >= lo && now - lo > 64'(max_span))
                    return close_clip(res);
                return 1'b0;
            end
            OP_TICK:
            begin
                if (clip_live && now >= 64'(last_mark) + 64'(post_len))
                    return close_clip(res);
                return 1'b0;
            end
            OP_FLUSH:
                return close_clip(res);
            OP_READ:
            begin
                res.kind = KIND_READ;
                {res.right_pcm, res.left_pcm} = ring_copy[beat.frame_index[RING_AW_DEF-1:0]];
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic string differing_fields(input result_t want, input result_t got);
        string s;
        s = "";
        if (got.kind !== want.kind)               s = {s, " kind"};
        if (got.clip_start !== want.clip_start)   s = {s, " clip_start"};
        if (got.clip_frames !== want.clip_frames) s = {s, " clip_frames"};
        if (got.clip_number !== want.clip_number) s = {s, " clip_number"};
        if (got.left_pcm !== want.left_pcm)       s = {s, " left_pcm"};
        if (got.right_pcm !== want.right_pcm)     s = {s, " right_pcm"};
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t produced;
        string   bad;
        if (!rst_n)
        begin
            for (int i = 0; i < RING_SLOTS; i++)
                ring_copy[i] = '0;
            frames_pushed  = '0;
            clip_live      = 1'b0;
            first_mark     = '0;
            last_mark      = '0;
            clips_emitted  = '0;
            pre_len        = '0;
            post_len       = '0;
            max_span       = MAX_FRAMES_RST;
            expected_beats.delete();
            expected_left  = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PRE:  pre_len  = cfg_data;
                    CFG_POST: post_len = cfg_data;
                    CFG_MAX:  max_span = cfg_data;
                    default:  ;
                endcase
            end
            // A result beat always belongs to an earlier item beat, so it is
            // checked before the item beat of the same edge is predicted.
            if (result_valid && !result_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result beat with nothing expected: kind=%0d start=%0d frames=%0d number=%0d left=%0d right=%0d",
                                 $realtime, result.kind, result.clip_start, result.clip_frames,
                                 result.clip_number, result.left_pcm, result.right_pcm);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    bad = differing_fields(want, result);
                    if (bad != "")
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: mismatch in%s: expected kind=%0d start=%0d frames=%0d number=%0d left=%0d right=%0d, got kind=%0d start=%0d frames=%0d number=%0d left=%0d right=%0d",
                                     $realtime, bad, want.kind, want.clip_start, want.clip_frames,
                                     want.clip_number, want.left_pcm, want.right_pcm,
                                     result.kind, result.clip_start, result.clip_frames,
                                     result.clip_number, result.left_pcm, result.right_pcm);
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                if (capture_step(item, produced))
                    expected_beats.insert(expected_beats.size(), produced);
            end
            expected_left = expected_beats.size();
        end
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Top of the pretrigger clip capture bench: clock, reset, stimulus and verdict.
// Depends on pcc_pkg, pretrigger_clip_capture and clip_capture_checker.
module tb_top;
    import pcc_pkg::*;

    // Op codes the block must ignore.
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Cycles to let the clip tracker drain after the last expected beat; an
    // event, tick or flush can still be in flight in the clip tracker.
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 item_valid;
    logic                 item_stall;
    item_t                item;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;

    int expected_left;
    int mismatch_count;

    // Idle percentages of the two sides, changed between phases.
    int send_idle_pct = 14;
    int recv_idle_pct = 48;

    // One long receiver hold-off, counted by the receiver process itself.
    bit hold_wanted = 1'b0;
    int hold_count  = 0;

    // Number of push beats sent so far; used to aim reads at recent frames.
    logic [FRAME_W-1:0] frames_offered = '0;
    int cycle_count = 0;

    pretrigger_clip_capture dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    clip_capture_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .expected_left  (expected_left),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, expected_left);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: stalls at random, except during the one long hold-off where it
    // refuses every result beat so that the block backs up into its input.
    always @(negedge clk)
    begin
        if (hold_wanted && hold_count < HOLD_CYCLES)
        begin
            hold_count   <= hold_count + 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    function automatic item_t beat_of(input logic [2:0] op, input logic signed [23:0] left,
                                      input logic signed [23:0] right,
                                      input logic [FRAME_W-1:0] index);
        item_t b;
        b.op           = op;
        b.left_sample  = left;
        b.right_sample = right;
        b.frame_index  = index;
        return b;
    endfunction

    // Samples: a mix of full-range values (half of them beyond +/-1.0 and so
    // clamped), in-range values and the values right at the clamp points.
    function automatic logic signed [23:0] random_sample();
        logic [23:0] u;
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1:
            begin
                u = 24'($urandom_range(0, 8388608));
                return u - 24'd4194304;
            end
            2:
            begin
                case ($urandom_range(0, 8))
                    0: return 24'sd4194304;
                    1: return 24'sd4194305;
                    2: return -24'sd4194304;
                    3: return -24'sd4194305;
                    4: return 24'h7FFFFF;
                    5: return 24'h800000;
                    6: return -24'sd1;
                    7: return 24'sd1;
                    default: return 24'sd0;
                endcase
            end
            default: return 24'($urandom_range(0, 2000)) - 24'sd1000;
        endcase
    endfunction

    // Random beat weighted toward clip traffic: pushes interleaved with events
    // and ticks build and close clips, reads sample the ring, a few flushes and
    // unused op codes go in as noise.
    function automatic item_t random_beat(input logic [FRAME_W-1:0] pushed);
        item_t b;
        int    pick;
        logic [15:0] back;
        b = beat_of(OP_PUSH, random_sample(), random_sample(), {16'($urandom), $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 40)
            b.op = OP_PUSH;
        else if (pick < 54)
            b.op = OP_EVENT;
        else if (pick < 70)
            b.op = OP_TICK;
        else if (pick < 75)
            b.op = OP_FLUSH;
        else if (pick < 95)
        begin
            b.op = OP_READ;
            // Half of the reads hit a recently written slot, upper bits random.
            if ($urandom_range(0, 1) == 0)
            begin
                back = 16'($urandom_range(1, 40));
                b.frame_index[15:0] = pushed[15:0] - back;
            end
        end
        else
            b.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        return b;
    endfunction

    // Offers one beat, starting and ending at a falling edge. The valid stays
    // high from the offer until the beat is taken, and the payload holds.
    task automatic send_item(input item_t beat);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (beat.op == OP_PUSH)
            frames_offered = frames_offered + 1'b1;
        @(negedge clk);
    endtask

    // Waits until every expected beat has come and the block has gone quiet.
    task automatic settle();
        item_valid <= 1'b0;
        while (expected_left != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_settings(input logic [CFG_W-1:0] pre, input logic [CFG_W-1:0] post,
                                  input logic [CFG_W-1:0] span);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PRE;
        cfg_data  <= pre;
        @(negedge clk);
        cfg_index <= CFG_POST;
        cfg_data  <= post;
        @(negedge clk);
        cfg_index <= CFG_MAX;
        cfg_data  <= span;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Sends random beats until the given number of meaningful ones have gone;
    // beats with an unused op code do not count.
    task automatic run_random(input int beats);
        item_t b;
        int    sent;
        sent = 0;
        while (sent < beats)
        begin
            b = random_beat(frames_offered);
            send_item(b);
            if (b.op <= OP_READ)
                sent++;
        end
    endtask

    initial
    begin
        // Reset falls just after time zero so every register sees its edge.
        rst_n      = 1'b1;
        cfg_we     = 1'b0;
        cfg_index  = CFG_PRE;
        cfg_data   = '0;
        item_valid = 1'b0;
        item       = '0;
        #1;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening: no pre or post context and a one-frame span limit,
        // so each clip rule shows up with short, easily followed windows.
        write_settings(24'd0, 24'd0, 24'd1);
        // Reads of slots never written, including the top slot.
        send_item(beat_of(OP_READ, 0, 0, 48'd0));
        send_item(beat_of(OP_READ, 0, 0, 48'hFFFF_FFFF_FFFF));
        // Tick and flush with no clip open do nothing; spare ops are ignored.
        send_item(beat_of(OP_TICK, 0, 0, 48'd0));
        send_item(beat_of(OP_FLUSH, 0, 0, 48'd0));
        send_item(beat_of(OP_SPARE_LO, 24'h7FFFFF, 24'h800000, 48'hFFFF_FFFF_FFFF));
        send_item(beat_of(OP_SPARE_HI, 0, 0, 48'd0));
        // Sample extremes, the clamp points and truncation toward zero.
        send_item(beat_of(OP_PUSH, 24'h7FFFFF, 24'h800000, 48'd0));
        send_item(beat_of(OP_PUSH, 24'sd4194304, -24'sd4194304, 48'd0));
        send_item(beat_of(OP_PUSH, 24'sd4194305, -24'sd4194305, 48'd0));
        send_item(beat_of(OP_PUSH, -24'sd1, 24'sd1, 48'd0));
        send_item(beat_of(OP_PUSH, 24'sd0, 24'sd0, 48'd0));
        // Reads take the index modulo the ring size whatever the upper bits.
        send_item(beat_of(OP_READ, 0, 0, 48'hABCD_0000_0001));
        send_item(beat_of(OP_READ, 0, 0, 48'h8000_0000_0002));
        // An event then a flush with no frame in between: empty window, no clip.
        send_item(beat_of(OP_EVENT, 0, 0, 48'd0));
        send_item(beat_of(OP_FLUSH, 0, 0, 48'd0));
        // The second event sees a two-frame span over the limit and closes.
        send_item(beat_of(OP_EVENT, 0, 0, 48'd0));
        send_item(beat_of(OP_PUSH, 24'sd1000000, -24'sd3000000, 48'd0));
        send_item(beat_of(OP_PUSH, -24'sd2500000, 24'sd700, 48'd0));
        send_item(beat_of(OP_EVENT, 0, 0, 48'd0));
        // A tick after one frame closes the clip, but with no post context the
        // window ends at the event itself and nothing is emitted.
        send_item(beat_of(OP_EVENT, 0, 0, 48'd0));
        send_item(beat_of(OP_PUSH, 24'sd4194303, -24'sd4194303, 48'd0));
        send_item(beat_of(OP_TICK, 0, 0, 48'd0));
        // A tick right after the event closes an empty clip silently.
        send_item(beat_of(OP_EVENT, 0, 0, 48'd0));
        send_item(beat_of(OP_TICK, 0, 0, 48'd0));
        send_item(beat_of(OP_READ, 0, 0, 48'd6));

        // Sender idles little, receiver much.
        write_settings(24'd4, 24'd3, 24'd24);
        run_random(150);
        // Largest context on both sides and no span allowed at all: ticks never
        // close, every repeated event after a push does.
        write_settings(24'hFFFFFF, 24'hFFFFFF, 24'd0);
        run_random(110);

        // Sender idles much, receiver little.
        send_idle_pct = 48;
        recv_idle_pct = 14;
        write_settings(24'($urandom_range(0, 40)), 24'($urandom_range(0, 12)),
                       24'($urandom_range(0, 60)));
        run_random(130);
        write_settings(24'd0, 24'd0, 24'hFFFFFF);
        run_random(90);

        // Neither side idles from here on.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_settings(24'd6, 24'd5, 24'd40);
        // The receiver holds off for a long stretch while beats keep coming.
        hold_wanted = 1'b1;
        run_random(60);
        // The sender pauses until the block has delivered everything.
        item_valid <= 1'b0;
        while (expected_left != 0)
            @(negedge clk);
        run_random(60);

        // Random pre context over the whole register range.
        write_settings(24'($urandom), 24'($urandom_range(0, 12)), 24'($urandom_range(0, 60)));
        run_random(130);

        settle();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[pretrigger_clip_capture.f]
+incdir+src
src/pcc_pkg.sv
src/pcc_ring.sv
src/pcc_clip.sv
src/pretrigger_clip_capture.sv
bench/clip_capture_checker.sv
bench/tb_top.sv
